// ----- rtl/csa_pkg.sv -----
// Shared types and codes for the credit slot allocator.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package csa_pkg;

    localparam int SLOT_W = 6;
    localparam int NODE_W = 8;
    localparam int ADDR_W = 48;
    localparam int TIME_W = 32;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;

    typedef enum logic [1:0] {
        ACT_SEND    = 2'd0,
        ACT_CREDIT  = 2'd1,
        ACT_ARRIVAL = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        KIND_SENT     = 3'd0,
        KIND_REFUSED  = 3'd1,
        KIND_CREDIT   = 3'd2,
        KIND_FREED    = 3'd3,
        KIND_BAD_SLOT = 3'd4
    } t_kind;

    typedef struct packed {
        logic              start;
        logic              upper;
        logic              step;
        logic              take;
        logic              release_en;
        logic [SLOT_W-1:0] release_slot;
    } t_scan_ctl;

    typedef struct packed {
        logic              hit;
        logic              last;
        logic [SLOT_W-1:0] pick;
    } t_scan_sts;

    typedef struct packed {
        logic lat_load;
        logic send_commit;
        logic arr_commit;
    } t_stats_ctl;

    typedef struct packed {
        logic [CNT_W-1:0]  sent;
        logic [CNT_W-1:0]  received;
        logic [SUM_W-1:0]  sum;
        logic [TIME_W-1:0] latency;
    } t_stats_val;

endpackage

`default_nettype wire

// ----- rtl/csa_if.sv -----
// Handshake channels of the allocator: request items in, result items out.
// Depends on csa_pkg for field widths.
`default_nettype none

interface csa_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    action;
    logic [1:0]                    request_class;
    logic [csa_pkg::NODE_W-1:0]    dest_node;
    logic [csa_pkg::ADDR_W-1:0]    address;
    logic [csa_pkg::SLOT_W-1:0]    slot;
    logic [csa_pkg::TIME_W-1:0]    entry_time;
    logic [csa_pkg::TIME_W-1:0]    current_time;

    modport source (output valid, action, request_class, dest_node, address, slot,
                    entry_time, current_time, input ready);
    modport sink   (input valid, action, request_class, dest_node, address, slot,
                    entry_time, current_time, output ready);
endinterface

interface csa_out_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    kind;
    logic [csa_pkg::SLOT_W-1:0]    out_slot;
    logic [csa_pkg::NODE_W-1:0]    out_src;
    logic [csa_pkg::NODE_W-1:0]    out_dest;
    logic [csa_pkg::ADDR_W-1:0]    out_address;
    logic [1:0]                    out_class;
    logic [csa_pkg::TIME_W-1:0]    stamp_time;
    logic [csa_pkg::TIME_W-1:0]    packet_latency;
    logic [csa_pkg::CNT_W-1:0]     sent_count;
    logic [csa_pkg::CNT_W-1:0]     received_count;
    logic [csa_pkg::SUM_W-1:0]     latency_sum;

    modport source (output valid, kind, out_slot, out_src, out_dest, out_address,
                    out_class, stamp_time, packet_latency, sent_count, received_count,
                    latency_sum, input ready);
    modport sink   (input valid, kind, out_slot, out_src, out_dest, out_address,
                    out_class, stamp_time, packet_latency, sent_count, received_count,
                    latency_sum, output ready);
endinterface

`default_nettype wire

// ----- rtl/credit_slot_allocator.sv -----
// Credit slot allocator top level: sequencer, item registers and result register.
// Path, accept to result valid: send goes through S_SCAN, the scan unit checking one slot per
// cycle, then S_DONE; credit goes to S_DONE; arrival through S_LAT, then S_DONE (subtract, then sum).
// One item at a time; a new item is taken while a result waits in the output register, and the
// next result waits until that one is taken.
// Synchronous active-low reset: all slots free, counters zero, own_node zero.
`default_nettype none

module credit_slot_allocator #(
    parameter int SLOT_COUNT = 4
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    csa_in_if.sink                       i_item,
    csa_out_if.source                    o_result,
    input  wire                          i_cfg_we,
    input  wire [csa_pkg::NODE_W-1:0]    i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_LAT  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [csa_pkg::NODE_W-1:0] r_own_node;
    logic [1:0]                 r_class;
    logic [csa_pkg::NODE_W-1:0] r_dest;
    logic [csa_pkg::ADDR_W-1:0] r_addr;
    logic [csa_pkg::SLOT_W-1:0] r_slot;
    logic [csa_pkg::TIME_W-1:0] r_entry;
    logic [csa_pkg::TIME_W-1:0] r_now;
    csa_pkg::t_kind             r_kind, n_kind;
    logic [csa_pkg::SLOT_W-1:0] r_pick, n_pick;

    logic                       r_out_valid;
    logic [2:0]                 r_o_kind;
    logic [csa_pkg::SLOT_W-1:0] r_o_slot;
    logic [csa_pkg::NODE_W-1:0] r_o_src;
    logic [csa_pkg::NODE_W-1:0] r_o_dest;
    logic [csa_pkg::ADDR_W-1:0] r_o_addr;
    logic [1:0]                 r_o_class;
    logic [csa_pkg::TIME_W-1:0] r_o_stamp;
    logic [csa_pkg::TIME_W-1:0] r_o_lat;
    logic [csa_pkg::CNT_W-1:0]  r_o_sent;
    logic [csa_pkg::CNT_W-1:0]  r_o_recv;
    logic [csa_pkg::SUM_W-1:0]  r_o_sum;

    logic                       w_accept;
    logic                       w_commit;
    logic                       w_slot_ok;
    csa_pkg::t_scan_ctl         w_scan_ctl;
    csa_pkg::t_scan_sts         w_scan_sts;
    csa_pkg::t_stats_ctl        w_stats_ctl;
    csa_pkg::t_stats_val        w_stats_val;

    assign i_item.ready = (r_state == S_IDLE);
    assign w_accept     = i_item.valid && (r_state == S_IDLE);
    assign w_commit     = (r_state == S_DONE) && (!r_out_valid || o_result.ready);
    assign w_slot_ok    = (7'(r_slot) < 7'(SLOT_COUNT));

    csa_slot_scan #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_scan_ctl),
        .o_sts   (w_scan_sts)
    );

    csa_stats u_stats (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_stats_ctl),
        .i_entry_time   (r_entry),
        .i_current_time (r_now),
        .o_val          (w_stats_val)
    );

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        n_pick  = r_pick;

        w_scan_ctl              = '0;
        w_scan_ctl.release_slot = r_slot;
        w_stats_ctl             = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (csa_pkg::t_action'(i_item.action))
                        csa_pkg::ACT_SEND: begin
                            w_scan_ctl.start = 1'b1;
                            w_scan_ctl.upper = (i_item.request_class != 2'd0);
                            n_state = S_SCAN;
                        end
                        csa_pkg::ACT_CREDIT: begin
                            n_state = S_DONE;
                        end
                        csa_pkg::ACT_ARRIVAL: begin
                            n_kind  = csa_pkg::KIND_CREDIT;
                            n_state = S_LAT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_scan_sts.hit) begin
                    n_kind  = csa_pkg::KIND_SENT;
                    n_pick  = w_scan_sts.pick;
                    n_state = S_DONE;
                end else if (w_scan_sts.last) begin
                    n_kind  = csa_pkg::KIND_REFUSED;
                    n_state = S_DONE;
                end else begin
                    w_scan_ctl.step = 1'b1;
                end
            end
            S_LAT: begin
                w_stats_ctl.lat_load = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (r_kind == csa_pkg::KIND_FREED || r_kind == csa_pkg::KIND_BAD_SLOT) begin
                    n_kind = w_slot_ok ? csa_pkg::KIND_FREED : csa_pkg::KIND_BAD_SLOT;
                end
                if (w_commit) begin
                    w_scan_ctl.take        = (r_kind == csa_pkg::KIND_SENT);
                    w_scan_ctl.release_en  = (n_kind == csa_pkg::KIND_FREED);
                    w_stats_ctl.send_commit = (r_kind == csa_pkg::KIND_SENT);
                    w_stats_ctl.arr_commit  = (r_kind == csa_pkg::KIND_CREDIT);
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_accept && i_item.action == csa_pkg::ACT_CREDIT) begin
            n_kind = csa_pkg::KIND_FREED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_own_node  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_own_node <= i_cfg_data;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_pick <= n_pick;
        if (w_accept) begin
            r_class <= i_item.request_class;
            r_dest  <= i_item.dest_node;
            r_addr  <= i_item.address;
            r_slot  <= i_item.slot;
            r_entry <= i_item.entry_time;
            r_now   <= i_item.current_time;
        end
        if (w_commit) begin
            r_o_kind  <= n_kind;
            r_o_sent  <= w_stats_val.sent;
            r_o_recv  <= w_stats_val.received;
            r_o_sum   <= w_stats_val.sum;
            case (r_kind)
                csa_pkg::KIND_SENT: begin
                    r_o_slot  <= r_pick;
                    r_o_src   <= r_own_node;
                    r_o_dest  <= r_dest;
                    r_o_addr  <= r_addr;
                    r_o_class <= r_class;
                    r_o_stamp <= r_now;
                    r_o_lat   <= '0;
                end
                csa_pkg::KIND_CREDIT: begin
                    r_o_slot  <= r_slot;
                    r_o_src   <= '0;
                    r_o_dest  <= '0;
                    r_o_addr  <= '0;
                    r_o_class <= '0;
                    r_o_stamp <= '0;
                    r_o_lat   <= w_stats_val.latency;
                end
                csa_pkg::KIND_FREED, csa_pkg::KIND_BAD_SLOT: begin
                    r_o_slot  <= r_slot;
                    r_o_src   <= '0;
                    r_o_dest  <= '0;
                    r_o_addr  <= '0;
                    r_o_class <= '0;
                    r_o_stamp <= '0;
                    r_o_lat   <= '0;
                end
                default: begin
                    r_o_slot  <= '0;
                    r_o_src   <= '0;
                    r_o_dest  <= '0;
                    r_o_addr  <= '0;
                    r_o_class <= '0;
                    r_o_stamp <= '0;
                    r_o_lat   <= '0;
                end
            endcase
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.kind           = r_o_kind;
    assign o_result.out_slot       = r_o_slot;
    assign o_result.out_src        = r_o_src;
    assign o_result.out_dest       = r_o_dest;
    assign o_result.out_address    = r_o_addr;
    assign o_result.out_class      = r_o_class;
    assign o_result.stamp_time     = r_o_stamp;
    assign o_result.packet_latency = r_o_lat;
    assign o_result.sent_count     = r_o_sent;
    assign o_result.received_count = r_o_recv;
    assign o_result.latency_sum    = r_o_sum;

endmodule

`default_nettype wire

// ----- rtl/csa_slot_scan.sv -----
// Slot free map and the one-slot-per-cycle first-free scan unit.
// Depends on csa_pkg (t_scan_ctl, t_scan_sts).
`default_nettype none

module csa_slot_scan #(
    parameter int SLOT_COUNT = 4
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  csa_pkg::t_scan_ctl     i_ctl,
    output csa_pkg::t_scan_sts     o_sts
);

    localparam int HALF = SLOT_COUNT / 2;
    localparam int IW   = $clog2(SLOT_COUNT);
    localparam int KW   = $clog2(HALF + 1);

    logic [SLOT_COUNT-1:0] r_free;
    logic [KW-1:0]         r_k;
    logic                  r_upper;
    logic [IW-1:0]         w_idx;
    logic [IW-1:0]         w_base;

    assign w_base = r_upper ? IW'(HALF) : '0;
    assign w_idx  = w_base + IW'(r_k);

    assign o_sts.hit  = r_free[w_idx];
    assign o_sts.last = (r_k == KW'(HALF - 1));
    assign o_sts.pick = csa_pkg::SLOT_W'(w_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= '1;
            r_k     <= '0;
            r_upper <= 1'b0;
        end else begin
            if (i_ctl.start) begin
                r_k     <= '0;
                r_upper <= i_ctl.upper;
            end else if (i_ctl.step) begin
                r_k <= r_k + KW'(1);
            end
            if (i_ctl.take) begin
                r_free[w_idx] <= 1'b0;
            end
            if (i_ctl.release_en) begin
                r_free[i_ctl.release_slot[IW-1:0]] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/csa_stats.sv -----
// Send/receive counters, latency subtract and latency sum accumulate.
// Depends on csa_pkg (t_stats_ctl, t_stats_val).
`default_nettype none

module csa_stats (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  csa_pkg::t_stats_ctl          i_ctl,
    input  wire [csa_pkg::TIME_W-1:0]    i_entry_time,
    input  wire [csa_pkg::TIME_W-1:0]    i_current_time,
    output csa_pkg::t_stats_val          o_val
);

    logic [csa_pkg::CNT_W-1:0]  r_sent;
    logic [csa_pkg::CNT_W-1:0]  r_received;
    logic [csa_pkg::SUM_W-1:0]  r_sum;
    logic [csa_pkg::TIME_W-1:0] r_lat;
    logic [csa_pkg::CNT_W-1:0]  n_sent;
    logic [csa_pkg::CNT_W-1:0]  n_received;
    logic [csa_pkg::SUM_W-1:0]  n_sum;

    always_comb begin
        n_sent     = r_sent;
        n_received = r_received;
        n_sum      = r_sum;
        if (i_ctl.send_commit) begin
            n_sent = r_sent + csa_pkg::CNT_W'(1);
        end
        if (i_ctl.arr_commit) begin
            n_received = r_received + csa_pkg::CNT_W'(1);
            n_sum      = r_sum + csa_pkg::SUM_W'(r_lat);
        end
    end

    assign o_val.sent     = n_sent;
    assign o_val.received = n_received;
    assign o_val.sum      = n_sum;
    assign o_val.latency  = r_lat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent     <= '0;
            r_received <= '0;
            r_sum      <= '0;
        end else begin
            r_sent     <= n_sent;
            r_received <= n_received;
            r_sum      <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.lat_load) begin
            r_lat <= i_current_time - i_entry_time;
        end
    end

endmodule

`default_nettype wire
